// ----- rtl/rif_pkg.sv -----
`default_nettype none
// RTP/RTCP ingress filter: shared types, constants and helpers.
// No dependencies; used by every module of the filter.

package rif_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_CONNECTED = 3'd0,
    CFG_PEER_IS_V6     = 3'd1,
    CFG_PEER_IP_HIGH   = 3'd2,
    CFG_PEER_IP_LOW    = 3'd3,
    CFG_RTP_PEER_PORT  = 3'd4,
    CFG_RTCP_PEER_PORT = 3'd5,
    CFG_LEARN_PORTS    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_DROP   = 2'd1,
    VERDICT_CLOSED = 2'd2
  } verdict_e;

  localparam logic [7:0]  RTCP_PT_MIN   = 8'd192;
  localparam logic [7:0]  RTCP_PT_MAX   = 8'd223;
  localparam logic [7:0]  HDR_CC_MASK   = 8'h0F;
  localparam logic [7:0]  HDR_X_FLAG    = 8'h10;
  localparam logic [7:0]  HDR_P_FLAG    = 8'h20;
  localparam logic [6:0]  RTP_FIXED_HDR = 7'd12;
  localparam logic [1:0]  RTP_VERSION   = 2'd2;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [17:0] HDR_MAX_END   = 18'h3FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       is_rtcp;
  } byte_item_t;

  typedef struct packed {
    logic        is_v6;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [15:0] port;
  } source_t;

  typedef struct packed {
    logic        pkt_ok;
    logic [15:0] size;
  } parse_res_t;

  typedef struct packed {
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  function automatic logic [17:0] sat_end(input logic [18:0] v);
    return v[18] ? HDR_MAX_END : v[17:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rif_parse.sv -----
`default_nettype none
// RTP/RTCP ingress filter: per-byte header parser and length checks.
// Depends on rif_pkg.

module rif_parse (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire rif_pkg::byte_item_t item,
  output rif_pkg::parse_res_t      res
);

  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [7:0]  hb0_r, hb0_nxt;
  logic [7:0]  hb1_r, hb1_nxt;
  logic [17:0] heo_r, heo_nxt;
  logic [7:0]  ext_hi_r, ext_hi_nxt;
  logic [7:0]  rtcp_hi_r, rtcp_hi_nxt;
  logic        malformed_r, malformed_nxt;

  logic [15:0] idx;
  logic [15:0] cnt;
  logic [3:0]  cc_cur, cc_new;
  logic [6:0]  hdr_cur, hdr_new;
  logic [16:0] rtcp_sum;
  logic [18:0] rtcp_end;
  logic [18:0] ext_end;
  logic [17:0] size_ext;
  logic [17:0] pad_room;
  logic        len_ok;
  logic        role_ok;

  always_comb begin
    idx      = item.first_byte ? 16'd0 : byte_offset_r;
    cnt      = (idx == rif_pkg::COUNT_MAX) ? rif_pkg::COUNT_MAX : idx + 16'd1;
    cc_cur   = 4'(hb0_r & rif_pkg::HDR_CC_MASK);
    cc_new   = 4'(item.data_byte & rif_pkg::HDR_CC_MASK);
    hdr_cur  = rif_pkg::RTP_FIXED_HDR + {1'b0, cc_cur, 2'b00};
    hdr_new  = rif_pkg::RTP_FIXED_HDR + {1'b0, cc_new, 2'b00};
    rtcp_sum = {1'b0, rtcp_hi_r, item.data_byte} + 17'd1;
    rtcp_end = {rtcp_sum, 2'b00};
    ext_end  = {1'b0, ext_hi_r, item.data_byte, 2'b00} + {12'd0, hdr_cur} + 19'd4;

    byte_offset_nxt = item.last_byte ? 16'd0 : cnt;
    hb0_nxt         = hb0_r;
    hb1_nxt         = hb1_r;
    heo_nxt         = heo_r;
    ext_hi_nxt      = ext_hi_r;
    rtcp_hi_nxt     = rtcp_hi_r;
    malformed_nxt   = malformed_r;

    if (idx == 16'd0) begin
      hb0_nxt       = item.data_byte;
      malformed_nxt = item.data_byte[7:6] != rif_pkg::RTP_VERSION;
      heo_nxt       = {11'd0, hdr_new} +
                      (((item.data_byte & rif_pkg::HDR_X_FLAG) != 8'd0) ? 18'd4 : 18'd0);
    end else if (idx == 16'd1) begin
      hb1_nxt = item.data_byte;
    end else if (idx == 16'd2) begin
      rtcp_hi_nxt = item.data_byte;
    end else if (idx == 16'd3 && item.is_rtcp) begin
      heo_nxt = rif_pkg::sat_end(rtcp_end);
    end

    if (idx >= 16'd4 && !item.is_rtcp && ((hb0_r & rif_pkg::HDR_X_FLAG) != 8'd0)) begin
      if (idx == {9'd0, hdr_cur} + 16'd2) begin
        ext_hi_nxt = item.data_byte;
      end else if (idx == {9'd0, hdr_cur} + 16'd3) begin
        heo_nxt = rif_pkg::sat_end(ext_end);
      end
    end

    // verdict sees the state as updated by this byte
    size_ext = {2'b00, cnt};
    pad_room = size_ext - heo_nxt;
    len_ok   = !malformed_nxt && cnt >= 16'd4 && heo_nxt <= size_ext;
    if (item.is_rtcp) begin
      role_ok = hb1_nxt >= rif_pkg::RTCP_PT_MIN && hb1_nxt <= rif_pkg::RTCP_PT_MAX;
    end else if ((hb0_nxt & rif_pkg::HDR_P_FLAG) != 8'd0) begin
      role_ok = item.data_byte != 8'd0 && {10'd0, item.data_byte} <= pad_room;
    end else begin
      role_ok = 1'b1;
    end
    res.pkt_ok = len_ok && role_ok;
    res.size   = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      hb0_r         <= '0;
      hb1_r         <= '0;
      heo_r         <= '0;
      ext_hi_r      <= '0;
      rtcp_hi_r     <= '0;
      malformed_r   <= 1'b0;
    end else if (fire) begin
      byte_offset_r <= byte_offset_nxt;
      hb0_r         <= hb0_nxt;
      hb1_r         <= hb1_nxt;
      heo_r         <= heo_nxt;
      ext_hi_r      <= ext_hi_nxt;
      rtcp_hi_r     <= rtcp_hi_nxt;
      malformed_r   <= malformed_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rif_peer.sv -----
`default_nettype none
// RTP/RTCP ingress filter: peer configuration, source match and port learning.
// Depends on rif_pkg.

module rif_peer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rif_pkg::cfg_wr_t cfg,
  input  wire logic             fire_last,
  input  wire logic             pkt_ok,
  input  wire logic             is_rtcp,
  input  wire rif_pkg::source_t src,
  output rif_pkg::verdict_e     verdict,
  output logic                  learned
);

  logic        link_r;
  logic        peer_v6_r;
  logic [63:0] peer_hi_r;
  logic [63:0] peer_lo_r;
  logic [15:0] pinned_r [2];
  logic        confirmed_r [2];

  logic host;
  logic learn;
  logic port_ok;

  always_comb begin
    if (src.is_v6 != peer_v6_r) begin
      host = 1'b0;
    end else if (src.is_v6) begin
      host = src.ip_high == peer_hi_r && src.ip_low == peer_lo_r;
    end else begin
      host = src.ip_low[31:0] == peer_lo_r[31:0];
    end
    learn   = pkt_ok && link_r && !confirmed_r[is_rtcp] && host;
    learned = learn;
    port_ok = learn || (pinned_r[is_rtcp] == src.port);
    if (!pkt_ok) begin
      verdict = rif_pkg::VERDICT_DROP;
    end else if (!link_r) begin
      verdict = rif_pkg::VERDICT_CLOSED;
    end else if (host && port_ok) begin
      verdict = rif_pkg::VERDICT_ACCEPT;
    end else begin
      verdict = rif_pkg::VERDICT_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r         <= 1'b0;
      peer_v6_r      <= 1'b0;
      peer_hi_r      <= '0;
      peer_lo_r      <= '0;
      pinned_r[0]    <= '0;
      pinned_r[1]    <= '0;
      confirmed_r[0] <= 1'b0;
      confirmed_r[1] <= 1'b0;
    end else if (cfg.wr_en) begin
      unique case (cfg.index)
        rif_pkg::CFG_LINK_CONNECTED: link_r    <= cfg.wdata[0];
        rif_pkg::CFG_PEER_IS_V6:     peer_v6_r <= cfg.wdata[0];
        rif_pkg::CFG_PEER_IP_HIGH:   peer_hi_r <= cfg.wdata;
        rif_pkg::CFG_PEER_IP_LOW:    peer_lo_r <= cfg.wdata;
        rif_pkg::CFG_RTP_PEER_PORT:  pinned_r[0] <= cfg.wdata[15:0];
        rif_pkg::CFG_RTCP_PEER_PORT: pinned_r[1] <= cfg.wdata[15:0];
        rif_pkg::CFG_LEARN_PORTS: begin
          confirmed_r[0] <= !cfg.wdata[0];
          confirmed_r[1] <= !cfg.wdata[0];
        end
        default: ;
      endcase
    end else if (fire_last && learn) begin
      pinned_r[is_rtcp]    <= src.port;
      confirmed_r[is_rtcp] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rtp_rtcp_ingress_filter_core.sv -----
`default_nettype none
// RTP/RTCP ingress filter top level: input register, parser, peer check and
// result register. Depends on rif_pkg, rif_parse and rif_peer.
//
//   channel | ports                               | handshake
//   --------+-------------------------------------+------------------------
//   input   | in_data_byte .. in_source_port      | in_valid / in_stall
//   result  | out_verdict .. out_packet_length    | out_valid / out_stall
//   config  | cfg_wr_en, cfg_index, cfg_wdata     | write on cfg_wr_en
//
// One byte per cycle while in_stall is low; a last byte goes through the
// input register, then the parse/check logic, into the result register.
// in_stall rises only when a last byte waits on a full, stalled result reg.
// Synchronous active-low reset clears parse state, pinned ports and config.

module rtp_rtcp_ingress_filter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_byte,
  input  wire logic        in_last_byte,
  input  wire logic        in_is_rtcp,
  input  wire logic        in_source_is_v6,
  input  wire logic [63:0] in_source_ip_high,
  input  wire logic [63:0] in_source_ip_low,
  input  wire logic [15:0] in_source_port,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_verdict,
  output logic             out_port_learned,
  output logic [15:0]      out_packet_length,

  input  wire logic                          cfg_wr_en,
  input  wire logic [rif_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rif_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rif_pkg::byte_item_t in_item_r;
  rif_pkg::source_t    in_src_r;
  logic                in_vld_r, in_vld_nxt;

  logic                out_vld_r, out_vld_nxt;
  rif_pkg::verdict_e   out_verdict_r;
  logic                out_learned_r;
  logic [15:0]         out_len_r;

  logic                out_free;
  logic                proceed;
  logic                fire_last;
  logic                in_take;

  rif_pkg::parse_res_t parse_res;
  rif_pkg::verdict_e   verdict;
  logic                learned;
  rif_pkg::cfg_wr_t    cfg;

  always_comb begin
    out_free    = !out_vld_r || !out_stall;
    proceed     = in_vld_r && (!in_item_r.last_byte || out_free);
    fire_last   = proceed && in_item_r.last_byte;
    in_stall    = in_vld_r && !proceed;
    in_take     = in_valid && !in_stall;
    in_vld_nxt  = in_take || (in_vld_r && !proceed);
    out_vld_nxt = fire_last || (out_vld_r && out_stall);
    cfg.wr_en   = cfg_wr_en;
    cfg.index   = cfg_index;
    cfg.wdata   = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.data_byte  <= in_data_byte;
      in_item_r.first_byte <= in_first_byte;
      in_item_r.last_byte  <= in_last_byte;
      in_item_r.is_rtcp    <= in_is_rtcp;
      in_src_r.is_v6       <= in_source_is_v6;
      in_src_r.ip_high     <= in_source_ip_high;
      in_src_r.ip_low      <= in_source_ip_low;
      in_src_r.port        <= in_source_port;
    end
    if (fire_last) begin
      out_verdict_r <= verdict;
      out_learned_r <= learned;
      out_len_r     <= parse_res.size;
    end
  end

  rif_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (proceed),
    .item  (in_item_r),
    .res   (parse_res)
  );

  rif_peer u_peer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire_last (fire_last),
    .pkt_ok    (parse_res.pkt_ok),
    .is_rtcp   (in_item_r.is_rtcp),
    .src       (in_src_r),
    .verdict   (verdict),
    .learned   (learned)
  );

  assign out_valid         = out_vld_r;
  assign out_verdict       = out_verdict_r;
  assign out_port_learned  = out_learned_r;
  assign out_packet_length = out_len_r;

  a_stall_only_on_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && in_item_r.last_byte && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire_last |=> out_vld_r)
    else $error("last byte processed but no result held");

  a_learn_means_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_port_learned) |-> (out_verdict == rif_pkg::VERDICT_ACCEPT))
    else $error("port learned on a packet that was not accepted");

  a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_packet_length != 16'd0))
    else $error("result with zero packet length");

endmodule

`default_nettype wire
